// File: hdl/usc_pkg.sv
package usc_pkg;

	localparam int MAX_KERNEL = 11;
	localparam int MAX_WIDTH  = 1024;
	localparam int COEF_BITS  = 16;
	localparam int NTAPS      = MAX_KERNEL * MAX_KERNEL;

	localparam int PIX_W     = 8;
	localparam int DIM_W     = 11;
	localparam int ROW_W     = DIM_W + 1;
	localparam int KS_W      = 4;
	localparam int THR_W     = 9;
	localparam int GAIN_W    = 12;
	localparam int GAIN_FRAC = 8;
	localparam int IDX_W     = 7;
	localparam int CFG_W     = 12;
	localparam int REG_W     = 3;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int J_W    = $clog2(MAX_KERNEL);
	localparam int H_W    = $clog2((MAX_KERNEL + 1) / 2);
	localparam int DLY_W  = H_W + DIM_W;
	localparam int PROD_W = PIX_W + COEF_BITS;
	localparam int ACC_W  = PROD_W + $clog2(MAX_KERNEL);
	localparam int TOT_W  = PROD_W + $clog2(NTAPS);
	localparam int DIFF_W = TOT_W + 1;
	localparam int MUL_W  = DIFF_W + GAIN_W + 1;
	localparam int VAL_W  = MUL_W + 1;
	localparam int SHIFT  = COEF_BITS + GAIN_FRAC;

	typedef enum logic [1:0] {
		FUNC_COEF  = 2'd0,
		FUNC_PIXEL = 2'd1,
		FUNC_PAD   = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [REG_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KSIZE  = 3'd2,
		REG_THRESH = 3'd3,
		REG_GAIN   = 3'd4
	} reg_t;

	// shared control for every cell of the chain
	typedef struct packed {
		logic                 rd_en;
		logic                 wr_en;
		logic [COL_W-1:0]     col;
		logic                 mul_en;
		logic [J_W-1:0]       j;
		logic                 col_ok;
		logic                 acc_clr;
		logic                 acc_en;
		logic                 drain_en;
		logic [H_W-1:0]       h;
		logic [J_W-1:0]       coef_col;
		logic [COEF_BITS-1:0] coef_val;
	} cell_ctl_t;

	typedef struct packed {
		logic [J_W-1:0] row;
		logic [J_W-1:0] col;
	} coef_pos_t;

	// row and column of a flat coefficient index (row * MAX_KERNEL + col)
	function automatic coef_pos_t coef_pos(input logic [IDX_W-1:0] idx);
		coef_pos_t p;
		p.row = '0;
		for (int r = 1; r < MAX_KERNEL; r++) begin
			if (idx >= IDX_W'(r * MAX_KERNEL)) begin
				p.row = J_W'(r);
			end
		end
		p.col = J_W'(idx - IDX_W'(int'(p.row) * MAX_KERNEL));
		return p;
	endfunction

endpackage

// File: hdl/usc_ifs.sv
interface usc_pix_if;
	import usc_pkg::*;
	logic                 valid;
	logic                 ready;
	func_t                func;
	logic [IDX_W-1:0]     coef_index;
	logic [COEF_BITS-1:0] coef_value;
	logic [PIX_W-1:0]     pixel;
	modport source (output valid, func, coef_index, coef_value, pixel, input ready);
	modport sink (input valid, func, coef_index, coef_value, pixel, output ready);
endinterface

interface usc_res_if;
	import usc_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] enhanced;
	logic             applied;
	logic             last_of_image;
	modport source (output valid, enhanced, applied, last_of_image, input ready);
	modport sink (input valid, enhanced, applied, last_of_image, output ready);
endinterface

interface usc_cfg_if;
	import usc_pkg::*;
	logic             valid;
	logic             ready;
	logic [REG_W-1:0] addr;
	logic [CFG_W-1:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: hdl/unsharp_mask_spatial_conv.sv
// Unsharp mask over a k x k smoothing window (k odd, up to 11), raster stream.
// Each pixel or pad item goes through the line buffer read and write; once the window of a center has filled,
// it then runs the k-step column sweep, the drain of the cell chain and the post stages POST1 and POST2,
// and the result waits until the result register is free. No new item is taken until the block is idle again.
// Reset: arst_n clears control, position counters and registers (640, 480, 5, 0, 256).
// Line and window storage is not cleared; entries outside the image are masked to zero.
module unsharp_mask_spatial_conv (
	input logic      clk,
	input logic      arst_n,
	usc_pix_if.sink  pix_in,
	usc_res_if.source res_out,
	usc_cfg_if.sink  cfg
);
	import usc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_WR, ST_SWEEP, ST_FLUSH, ST_DRAIN, ST_POST1, ST_POST2, ST_DONE
	} state_t;

	// ---------------- configuration registers ----------------
	logic [DIM_W-1:0]        width_q, height_q;
	logic [KS_W-1:0]         ksize_q;
	logic signed [THR_W-1:0] thr_q;
	logic [GAIN_W-1:0]       gain_q;
	logic                    cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
			ksize_q  <= KS_W'(5);
			thr_q    <= '0;
			gain_q   <= GAIN_W'(256);
		end else if (cfg_fire) begin
			case (cfg.addr)
				REG_WIDTH:  width_q  <= cfg.data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[DIM_W-1:0];
				REG_KSIZE:  ksize_q  <= cfg.data[KS_W-1:0];
				REG_THRESH: thr_q    <= $signed(cfg.data[THR_W-1:0]);
				REG_GAIN:   gain_q   <= cfg.data[GAIN_W-1:0];
				default:    ;
			endcase
		end
	end

	// ---------------- effective geometry ----------------
	// zero sizes act as 1, width caps at the line buffer depth, even k rounds down
	logic [DIM_W-1:0] w_eff, hgt_eff;
	logic [KS_W-1:0]  k_sat;
	logic [H_W-1:0]   half;
	logic [J_W-1:0]   kk;
	logic [DLY_W-1:0] delay;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		hgt_eff = (height_q == '0) ? DIM_W'(1) : height_q;
		if (ksize_q > KS_W'(MAX_KERNEL)) begin
			k_sat = KS_W'(MAX_KERNEL);
		end else if (ksize_q == '0) begin
			k_sat = KS_W'(1);
		end else begin
			k_sat = ksize_q;
		end
		half  = H_W'((k_sat - 1'b1) >> 1);
		kk    = J_W'({half, 1'b1});
		// stream distance between the newest item and the window center
		delay = DLY_W'(half) * DLY_W'(w_eff) + DLY_W'(half);
	end

	// ---------------- sequencer ----------------
	state_t                 state_q;
	logic [COL_W-1:0]       col_q, col_lat_q;
	logic [DLY_W-1:0]       cnt_q;
	logic [DIM_W-1:0]       cr_q;
	logic [COL_W-1:0]       cc_q, ctr_c_q;
	logic                   due_q, last_q;
	logic [MAX_KERNEL-1:0]  row_ok_q, row_ok_d;
	logic [PIX_W-1:0]       pix_lat_q;
	logic [J_W-1:0]         j_q, dr_q;
	logic [TOT_W-1:0]       tot_q;
	logic                   out_valid_q;
	logic [PIX_W-1:0]       enh_q;
	logic                   app_q, last_out_q;

	logic                   in_fire, is_last, out_free, out_load;
	logic [ROW_W-1:0]       r_plus;
	logic [DIM_W-1:0]       c_plus;
	logic                   col_ok;
	logic [PIX_W-1:0]       res_pix;
	logic                   res_app;

	assign in_fire      = pix_in.valid & pix_in.ready;
	assign pix_in.ready = (state_q == ST_IDLE);
	assign out_free     = !out_valid_q || res_out.ready;
	// result register takes a new result; an outgoing transfer in the same cycle is replaced
	assign out_load     = (state_q == ST_DONE) && out_free;
	assign is_last      = (cr_q == DIM_W'(hgt_eff - 1'b1))
		&& (DIM_W'(cc_q) == DIM_W'(w_eff - 1'b1));

	// vertical padding: which kernel rows hit image rows for this center
	always_comb begin
		r_plus = ROW_W'(cr_q) + ROW_W'(half);
		for (int i = 0; i < MAX_KERNEL; i++) begin
			row_ok_d[i] = (J_W'(i) < kk) && (r_plus >= ROW_W'(i))
				&& ((r_plus - ROW_W'(i)) < ROW_W'(hgt_eff));
		end
	end

	// horizontal padding for the column under sweep
	always_comb begin
		c_plus = DIM_W'(ctr_c_q) + DIM_W'(half);
		col_ok = (c_plus >= DIM_W'(j_q)) && ((c_plus - DIM_W'(j_q)) < w_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			col_lat_q   <= '0;
			cnt_q       <= '0;
			cr_q        <= '0;
			cc_q        <= '0;
			ctr_c_q     <= '0;
			due_q       <= 1'b0;
			last_q      <= 1'b0;
			row_ok_q    <= '0;
			pix_lat_q   <= '0;
			j_q         <= '0;
			dr_q        <= '0;
			out_valid_q <= 1'b0;
			enh_q       <= '0;
			app_q       <= 1'b0;
			last_out_q  <= 1'b0;
		end else begin
			if (res_out.valid && res_out.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && (pix_in.func == FUNC_PIXEL || pix_in.func == FUNC_PAD)) begin
						col_lat_q <= col_q;
						pix_lat_q <= (pix_in.func == FUNC_PIXEL) ? pix_in.pixel : '0;
						row_ok_q  <= row_ok_d;
						ctr_c_q   <= cc_q;
						last_q    <= is_last;
						state_q   <= ST_RD;
						// due only once the window of the first center has filled
						due_q     <= (cnt_q >= delay);
						if ((cnt_q >= delay) && is_last) begin
							// bottom-right center: next item starts a new image
							col_q <= '0;
							cnt_q <= '0;
							cr_q  <= '0;
							cc_q  <= '0;
						end else begin
							if ((DIM_W'(col_q) + 1'b1) >= w_eff) begin
								col_q <= '0;
							end else begin
								col_q <= col_q + 1'b1;
							end
							if (cnt_q < delay) begin
								cnt_q <= cnt_q + 1'b1;
							end else if ((DIM_W'(cc_q) + 1'b1) >= w_eff) begin
								cc_q <= '0;
								cr_q <= cr_q + 1'b1;
							end else begin
								cc_q <= cc_q + 1'b1;
							end
						end
					end else if (cfg_fire && (cfg.addr == REG_WIDTH
						|| cfg.addr == REG_HEIGHT || cfg.addr == REG_KSIZE)) begin
						// geometry change restarts the image
						col_q <= '0;
						cnt_q <= '0;
						cr_q  <= '0;
						cc_q  <= '0;
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					j_q     <= '0;
					state_q <= due_q ? ST_SWEEP : ST_IDLE;
				end
				ST_SWEEP: begin
					if (j_q == J_W'(kk - 1'b1)) begin
						state_q <= ST_FLUSH;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					dr_q    <= '0;
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (dr_q == J_W'(MAX_KERNEL - 1)) begin
						state_q <= ST_POST1;
					end else begin
						dr_q <= dr_q + 1'b1;
					end
				end
				ST_POST1: state_q <= ST_POST2;
				ST_POST2: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						enh_q       <= res_pix;
						app_q       <= res_app;
						last_out_q  <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.enhanced      = enh_q;
	assign res_out.applied       = app_q;
	assign res_out.last_of_image = last_out_q;

	// ---------------- cell chain ----------------
	cell_ctl_t             ctl;
	coef_pos_t             cpos;
	logic [MAX_KERNEL-1:0] coef_we;
	logic [PIX_W-1:0]      pix_chain [MAX_KERNEL];
	logic [ACC_W-1:0]      acc_chain [MAX_KERNEL];
	logic [PIX_W-1:0]      ctr_chain [MAX_KERNEL];

	assign cpos = coef_pos(pix_in.coef_index);

	always_comb begin
		ctl.rd_en    = (state_q == ST_RD);
		ctl.wr_en    = (state_q == ST_WR);
		ctl.col      = col_lat_q;
		ctl.mul_en   = (state_q == ST_SWEEP);
		ctl.j        = j_q;
		ctl.col_ok   = col_ok;
		ctl.acc_clr  = (state_q == ST_WR);
		// products are registered, so each lands in the cycle after its sweep step
		ctl.acc_en   = ((state_q == ST_SWEEP) && (j_q != '0)) || (state_q == ST_FLUSH);
		ctl.drain_en = (state_q == ST_DRAIN);
		ctl.h        = half;
		ctl.coef_col = cpos.col;
		ctl.coef_val = pix_in.coef_value;
		for (int i = 0; i < MAX_KERNEL; i++) begin
			coef_we[i] = in_fire && (pix_in.func == FUNC_COEF)
				&& (pix_in.coef_index < IDX_W'(NTAPS)) && (cpos.row == J_W'(i));
		end
	end

	// cell i sees the stream delayed by i rows; row sums shift out toward the last cell
	for (genvar gi = 0; gi < MAX_KERNEL; gi++) begin : g_cell
		logic [PIX_W-1:0] cell_pix;
		logic [ACC_W-1:0] cell_acc;
		if (gi == 0) begin : g_head
			assign cell_pix = pix_lat_q;
			assign cell_acc = '0;
		end else begin : g_body
			assign cell_pix = pix_chain[gi-1];
			assign cell_acc = acc_chain[gi-1];
		end
		usc_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.row_ok  (row_ok_q[gi]),
			.coef_we (coef_we[gi]),
			.pix_in  (cell_pix),
			.pix_out (pix_chain[gi]),
			.acc_in  (cell_acc),
			.acc_out (acc_chain[gi]),
			.ctr_px  (ctr_chain[gi])
		);
	end

	// ---------------- sum and sharpen ----------------
	logic signed [DIFF_W-1:0] diff_d, thr_sh, diff_s1;
	logic                     app_s1, app_s2;
	logic [PIX_W-1:0]         ctr_s1, ctr_s2, centre;
	logic signed [MUL_W-1:0]  mul_s2;
	logic signed [VAL_W-1:0]  ctr_sh, val;
	logic [VAL_W-1:0]         rnd;
	logic [VAL_W-SHIFT-1:0]   scaled;

	assign centre = ctr_chain[J_W'(half)];

	always_comb begin
		diff_d = $signed(DIFF_W'({centre, {COEF_BITS{1'b0}}})) - $signed({1'b0, tot_q});
		thr_sh = {{(DIFF_W - THR_W - COEF_BITS){thr_q[THR_W-1]}}, thr_q, {COEF_BITS{1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FLUSH) begin
			tot_q <= '0;
		end else if (state_q == ST_DRAIN) begin
			tot_q <= tot_q + TOT_W'(acc_chain[MAX_KERNEL-1]);
		end
		if (state_q == ST_POST1) begin
			diff_s1 <= diff_d;
			app_s1  <= (diff_d > thr_sh);
			ctr_s1  <= centre;
		end
		if (state_q == ST_POST2) begin
			mul_s2 <= diff_s1 * $signed({1'b0, gain_q});
			app_s2 <= app_s1;
			ctr_s2 <= ctr_s1;
		end
	end

	// clamp at zero, round half up, saturate to 8 bits; if not applied, pass the centre pixel
	always_comb begin
		ctr_sh = $signed(VAL_W'({ctr_s2, {SHIFT{1'b0}}}));
		val    = ctr_sh + $signed({mul_s2[MUL_W-1], mul_s2});
		rnd    = val[VAL_W-1] ? '0 : (VAL_W'(val) + (VAL_W'(1) << (SHIFT - 1)));
		scaled = rnd[VAL_W-1:SHIFT];
		if (|scaled[VAL_W-SHIFT-1:PIX_W]) begin
			res_pix = '1;
		end else begin
			res_pix = scaled[PIX_W-1:0];
		end
		if (!app_s2) begin
			res_pix = ctr_s2;
		end
		res_app = app_s2;
	end

	// ---------------- checks ----------------
	a_coef_we_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(coef_we))
		else $error("coefficient written to more than one cell");

	a_center_row_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> row_ok_q[J_W'(half)])
		else $error("center row masked as padding");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= delay))
		else $error("fill count beyond window delay");

	a_pixel_starts_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (pix_in.func == FUNC_PIXEL || pix_in.func == FUNC_PAD))
		|=> (state_q == ST_RD))
		else $error("stream item did not start a line buffer read");

endmodule

// File: hdl/usc_cell.sv
module usc_cell (
	input  logic                                clk,
	input  usc_pkg::cell_ctl_t                  ctl,
	input  logic                                row_ok,
	input  logic                                coef_we,
	input  logic [usc_pkg::PIX_W-1:0]           pix_in,
	output logic [usc_pkg::PIX_W-1:0]           pix_out,
	input  logic [usc_pkg::ACC_W-1:0]           acc_in,
	output logic [usc_pkg::ACC_W-1:0]           acc_out,
	output logic [usc_pkg::PIX_W-1:0]           ctr_px
);
	import usc_pkg::*;

	logic [PIX_W-1:0]     mem [MAX_WIDTH];
	logic [PIX_W-1:0]     rd_q;
	logic [PIX_W-1:0]     win_q [MAX_KERNEL];
	logic [COEF_BITS-1:0] coef_q [MAX_KERNEL];
	logic [PROD_W-1:0]    prod_s1;
	logic [ACC_W-1:0]     acc_q;

	// one-row delay line: read old pixel, then write the incoming one
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.col];
		end
		if (ctl.wr_en) begin
			mem[ctl.col] <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			win_q[0] <= pix_in;
			for (int n = 1; n < MAX_KERNEL; n++) begin
				win_q[n] <= win_q[n-1];
			end
		end
		if (coef_we) begin
			coef_q[ctl.coef_col] <= ctl.coef_val;
		end
		if (ctl.mul_en && row_ok && ctl.col_ok) begin
			prod_s1 <= win_q[ctl.j] * coef_q[ctl.j];
		end else begin
			prod_s1 <= '0;
		end
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end else if (ctl.drain_en) begin
			acc_q <= acc_in;
		end
	end

	assign pix_out = rd_q;
	assign acc_out = acc_q;
	assign ctr_px  = win_q[J_W'(ctl.h)];

endmodule

// File: verif/tb_unsharp_mask_spatial_conv.sv
module tb_unsharp_mask_spatial_conv;
	import usc_pkg::*;

	// pixel history depth: (MAX_KERNEL-1) full rows plus one window row
	localparam int HIST = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;

	typedef struct {
		func_t                func;
		logic [IDX_W-1:0]     coef_index;
		logic [COEF_BITS-1:0] coef_value;
		logic [PIX_W-1:0]     pixel;
	} pix_item_t;

	typedef struct {
		logic [PIX_W-1:0] enhanced;
		logic             applied;
		logic             last_of_image;
	} sharp_res_t;

	logic clk;
	logic arst_n;

	usc_pix_if pix_if();
	usc_res_if res_if();
	usc_cfg_if cfg_if();

	unsharp_mask_spatial_conv dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	// stimulus and scoreboard storage
	pix_item_t  item_q[$];
	sharp_res_t sharpened_q[$];
	int         errors = 0;
	int         pix_sent = 0;
	int         results_seen = 0;
	bit         pix_took = 0;
	bit         res_took = 0;

	// shadow of the block: registers, coefficient store, pixel history, position
	logic [DIM_W-1:0]       width_q;
	logic [DIM_W-1:0]       height_q;
	logic [KS_W-1:0]        ksize_q;
	logic signed [THR_W-1:0] thresh_q;
	logic [GAIN_W-1:0]      gain_q;
	logic [COEF_BITS-1:0]   kernel_taps[NTAPS];
	logic [PIX_W-1:0]       pixel_hist[HIST];
	int                     row_q, col_q;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// every input known from time zero
	initial begin
		arst_n            = 1'b0;
		pix_if.valid      = 1'b0;
		pix_if.func       = FUNC_NONE;
		pix_if.coef_index = '0;
		pix_if.coef_value = '0;
		pix_if.pixel      = '0;
		res_if.ready      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.addr       = '0;
		cfg_if.data       = '0;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#60000000;
		$display("status: fail");
		$finish;
	end

	function automatic int eff_width();
		if (width_q == 0) return 1;
		if (width_q > MAX_WIDTH) return MAX_WIDTH;
		return int'(width_q);
	endfunction

	function automatic int eff_height();
		return (height_q == 0) ? 1 : int'(height_q);
	endfunction

	function automatic int eff_half();
		int ks;
		ks = int'(ksize_q);
		if (ks > MAX_KERNEL) ks = MAX_KERNEL;
		if (ks == 0) ks = 1;
		return (ks - 1) / 2;
	endfunction

	function automatic void apply_reg(logic [REG_W-1:0] addr, logic [CFG_W-1:0] data);
		case (reg_t'(addr))
			REG_WIDTH: begin
				width_q = data[DIM_W-1:0];
				row_q = 0;
				col_q = 0;
			end
			REG_HEIGHT: begin
				height_q = data[DIM_W-1:0];
				row_q = 0;
				col_q = 0;
			end
			REG_KSIZE: begin
				ksize_q = data[KS_W-1:0];
				row_q = 0;
				col_q = 0;
			end
			REG_THRESH: thresh_q = data[THR_W-1:0];
			REG_GAIN:   gain_q = data[GAIN_W-1:0];
			default: ;
		endcase
	endfunction

	// Predict the sharpened output caused by one accepted item, if any.
	function automatic void predict_sharpen(pix_item_t it);
		int         ww, hh, hf, kk;
		longint     pos, dly, tot, ctr, r, c, rr, cc, acc, diff, val, centre, thr;
		longint     rv;
		longint     px;
		sharp_res_t e;
		if (it.func == FUNC_COEF) begin
			if (it.coef_index < NTAPS) kernel_taps[it.coef_index] = it.coef_value;
			return;
		end
		if (it.func == FUNC_NONE) return;
		ww = eff_width();
		hh = eff_height();
		hf = eff_half();
		kk = 2 * hf + 1;
		pos = longint'(row_q) * ww + col_q;
		pixel_hist[pos % HIST] = (it.func == FUNC_PIXEL) ? it.pixel : '0;
		col_q++;
		if (col_q >= ww) begin
			col_q = 0;
			row_q++;
		end
		dly = longint'(hf) * ww + hf;
		tot = longint'(ww) * hh;
		if (pos < dly) return;
		ctr = pos - dly;
		if (ctr >= tot) begin
			row_q = 0;
			col_q = 0;
			return;
		end
		r = ctr / ww;
		c = ctr % ww;
		acc = 0;
		// true convolution: tap (i,j) meets the pixel at (r+h-i, c+h-j), zero outside
		for (int i = 0; i < kk; i++) begin
			for (int j = 0; j < kk; j++) begin
				rr = r + hf - i;
				cc = c + hf - j;
				px = 0;
				if (rr >= 0 && cc >= 0 && rr < hh && cc < ww)
					px = longint'(pixel_hist[(rr * ww + cc) % HIST]);
				acc += px * longint'(kernel_taps[i * MAX_KERNEL + j]);
			end
		end
		centre = longint'(pixel_hist[ctr % HIST]);
		diff = (centre <<< COEF_BITS) - acc;
		thr = longint'(thresh_q);
		if (diff > (thr <<< COEF_BITS)) begin
			e.applied = 1'b1;
			val = (centre <<< SHIFT) + diff * longint'(gain_q);
			if (val < 0) val = 0;
			rv = (val + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
			if (rv > 255) rv = 255;
			e.enhanced = PIX_W'(rv);
		end else begin
			e.applied = 1'b0;
			e.enhanced = PIX_W'(centre);
		end
		e.last_of_image = (ctr == tot - 1);
		if (e.last_of_image) begin
			row_q = 0;
			col_q = 0;
		end
		sharpened_q.push_back(e);
	endfunction

	// Input side: predict at each accepted pixel-channel transfer.
	always @(posedge clk) begin
		pix_took = pix_if.valid && pix_if.ready;
		if (pix_took) begin
			pix_item_t it;
			it.func       = pix_if.func;
			it.coef_index = pix_if.coef_index;
			it.coef_value = pix_if.coef_value;
			it.pixel      = pix_if.pixel;
			predict_sharpen(it);
		end
	end

	// Output side: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		res_took = res_if.valid && res_if.ready;
		if (res_took) begin
			results_seen++;
			if (sharpened_q.size() == 0) begin
				$error("unexpected result: enhanced=%0d applied=%0d last=%0d",
					res_if.enhanced, res_if.applied, res_if.last_of_image);
				errors++;
			end else begin
				sharp_res_t e;
				e = sharpened_q.pop_front();
				if (res_if.enhanced !== e.enhanced) begin
					$error("enhanced: expected %0d, got %0d", e.enhanced, res_if.enhanced);
					errors++;
				end
				if (res_if.applied !== e.applied) begin
					$error("applied: expected %0d, got %0d", e.applied, res_if.applied);
					errors++;
				end
				if (res_if.last_of_image !== e.last_of_image) begin
					$error("last_of_image: expected %0d, got %0d",
						e.last_of_image, res_if.last_of_image);
					errors++;
				end
			end
		end
	end

	// Driver: one item per transfer, a random gap after each, with calm stretches.
	int drv_gap = 0;
	bit drv_calm = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			pix_if.valid <= 1'b0;
		end else if (!(pix_if.valid && !pix_took)) begin
			if (drv_gap > 0) begin
				drv_gap--;
				pix_if.valid <= 1'b0;
			end else if (item_q.size() != 0) begin
				pix_item_t it;
				it = item_q.pop_front();
				pix_if.func       <= it.func;
				pix_if.coef_index <= it.coef_index;
				pix_if.coef_value <= it.coef_value;
				pix_if.pixel      <= it.pixel;
				pix_if.valid      <= 1'b1;
				if ($urandom_range(0, 49) == 0) drv_calm = !drv_calm;
				drv_gap = drv_calm ? 0 : $urandom_range(0, 12);
			end else begin
				pix_if.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall per transfer, plus one long hold-off to back up the block.
	int  rcv_wait = 0;
	int  long_hold = 0;
	bit  hold_done = 0;
	bit  rcv_calm = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_took) begin
				if ($urandom_range(0, 49) == 0) rcv_calm = !rcv_calm;
				rcv_wait = rcv_calm ? 0 : $urandom_range(0, 12);
			end
			if (!hold_done && results_seen >= 100) begin
				hold_done = 1;
				long_hold = 600;
			end
			if (long_hold > 0) begin
				long_hold--;
				res_if.ready <= 1'b0;
			end else if (rcv_wait > 0) begin
				rcv_wait--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Register write over the config channel; block must be idle.
	task automatic write_reg(reg_t addr, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_if.addr  <= addr;
		cfg_if.data  <= data;
		cfg_if.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		apply_reg(addr, data);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// Drain everything, then wait out the block's processing of items without results.
	task automatic settle();
		while (item_q.size() != 0 || pix_if.valid || sharpened_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic push_item(func_t f, int idx, int val, int pix);
		pix_item_t it;
		it.func       = f;
		it.coef_index = IDX_W'(idx);
		it.coef_value = COEF_BITS'(val);
		it.pixel      = PIX_W'(pix);
		item_q.push_back(it);
		if (f == FUNC_PIXEL || f == FUNC_PAD) pix_sent++;
	endtask

	// Load the k x k corner of the coefficient store: uniform blur, small random, or full random.
	task automatic load_taps(int kk, int mode);
		int v;
		for (int i = 0; i < kk; i++) begin
			for (int j = 0; j < kk; j++) begin
				case (mode)
					0: v = 65536 / (kk * kk);
					1: v = $urandom_range(0, 2 * 65536 / (kk * kk));
					default: v = $urandom_range(0, 65535);
				endcase
				push_item(FUNC_COEF, i * MAX_KERNEL + j, v, 0);
			end
		end
	endtask

	task automatic setup(int w, int h, int ks, int thr, int g);
		settle();
		write_reg(REG_WIDTH, {1'($urandom), 11'(w)});
		write_reg(REG_HEIGHT, {1'($urandom), 11'(h)});
		write_reg(REG_KSIZE, {8'($urandom), 4'(ks)});
		write_reg(REG_THRESH, {3'($urandom), 9'(thr)});
		write_reg(REG_GAIN, 12'(g));
	endtask

	function automatic int rand_pixel();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	// One image in raster order, with pads, noise and, if complete, the trailing flush.
	task automatic stream_image(int npix, bit complete);
		int ww, hf, flush;
		ww = eff_width();
		hf = eff_half();
		flush = hf * ww + hf;
		for (int p = 0; p < npix; p++) begin
			if ($urandom_range(0, 19) == 0) push_item(FUNC_NONE, $urandom, $urandom, $urandom);
			if ($urandom_range(0, 19) == 0) push_item(FUNC_PAD, 0, 0, $urandom);
			else push_item(FUNC_PIXEL, $urandom, $urandom, rand_pixel());
		end
		if (complete) begin
			// positions past the image: pads, or pixels whose value is never used
			for (int p = 0; p < flush; p++) begin
				if ($urandom_range(0, 1)) push_item(FUNC_PAD, 0, 0, $urandom);
				else push_item(FUNC_PIXEL, 0, 0, rand_pixel());
			end
		end
	endtask

	initial begin
		int w, h, ks, ke, thr, g, pick, npix;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		width_q  = 11'd640;
		height_q = 11'd480;
		ksize_q  = 4'd5;
		thresh_q = '0;
		gain_q   = 12'd256;
		row_q = 0;
		col_q = 0;

		// every coefficient written before any pixel; out-of-range index is dropped
		load_taps(MAX_KERNEL, 2);
		push_item(FUNC_COEF, 127, 16'hFFFF, 0);
		push_item(FUNC_NONE, 0, 0, 0);

		// directed 3x3 image: lowest threshold, highest gain, extreme pixels, pad inside
		setup(3, 3, 3, -256, 4095);
		load_taps(3, 0);
		push_item(FUNC_PIXEL, 0, 0, 0);
		push_item(FUNC_PIXEL, 0, 0, 255);
		push_item(FUNC_PIXEL, 0, 0, 8'h55);
		push_item(FUNC_PAD, 0, 0, 255);
		push_item(FUNC_PIXEL, 0, 0, 8'hAA);
		push_item(FUNC_NONE, 0, 0, 0);
		push_item(FUNC_PIXEL, 0, 0, 255);
		push_item(FUNC_PIXEL, 0, 0, 0);
		push_item(FUNC_PIXEL, 0, 0, 255);
		push_item(FUNC_PIXEL, 0, 0, 1);
		push_item(FUNC_PIXEL, 0, 0, 200);
		push_item(FUNC_PAD, 0, 0, 0);
		push_item(FUNC_PIXEL, 0, 0, 77);
		push_item(FUNC_PAD, 0, 0, 0);

		// directed: highest threshold, zero gain, zero sizes used as one
		setup(0, 0, 0, 255, 0);
		stream_image(1, 1);

		// random images, mostly small; a few at the widest and tallest, left unfinished
		while (pix_sent < 1050) begin
			pick = $urandom_range(0, 24);
			if ($urandom_range(0, 3) == 0) ks = $urandom_range(0, 15);
			else ks = 2 * $urandom_range(0, 5) + 1;
			case ($urandom_range(0, 5))
				0: thr = -256;
				1: thr = 255;
				2: thr = $urandom_range(0, 511) - 256;
				default: thr = $urandom_range(0, 40) - 20;
			endcase
			case ($urandom_range(0, 4))
				0: g = 0;
				1: g = 4095;
				default: g = $urandom_range(0, 1023);
			endcase
			if (pick == 0) begin
				w = $urandom_range(0, 1) ? 2047 : 1024;
				h = $urandom_range(1, 3);
				npix = 30;
			end else if (pick == 1) begin
				w = $urandom_range(1, 4);
				h = $urandom_range(0, 1) ? 2047 : 1024;
				npix = 30;
			end else begin
				w = $urandom_range(1, 10);
				h = $urandom_range(1, 6);
				npix = 0;
			end
			setup(w, h, ks, thr, g);
			ke = 2 * eff_half() + 1;
			if ($urandom_range(0, 2) == 0) load_taps(ke, $urandom_range(0, 2));
			if (npix == 0) stream_image(eff_width() * eff_height(), 1);
			else stream_image(npix, 0);
		end

		settle();
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/usc_pkg.sv
hdl/usc_ifs.sv
hdl/usc_cell.sv
hdl/unsharp_mask_spatial_conv.sv
verif/tb_unsharp_mask_spatial_conv.sv
